@@ hw/rtl/tlvom_pkg.sv @@
// Shared types, opcodes and index helpers for the two-level voxel occupancy map.
package tlvom_pkg;

	localparam int unsigned COORD_W  = 4;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned BRICK_W  = 6;
	localparam int unsigned VBIT_W   = 6;
	localparam int unsigned SLOT_W   = BRICK_W + VBIT_W;
	localparam int unsigned MASK_W   = 64;
	localparam int unsigned VALUE_W  = 32;

	// Operation codes carried in the operation field.
	typedef enum logic [OP_W-1:0] {
		OP_SET     = 2'd0,
		OP_CLR_ONE = 2'd1,
		OP_CLR_ALL = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// One edit request.
	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [COORD_W-1:0] z_coord;
		logic [VALUE_W-1:0] voxel_value;
	} req_t;

	// One result.
	typedef struct packed {
		logic [MASK_W-1:0]  top_mask;
		logic [MASK_W-1:0]  brick_mask;
		logic               brick_present;
		logic               voxel_occupied;
		logic [VALUE_W-1:0] stored_value;
	} rsp_t;

	// Write enables produced by the update logic.
	typedef struct packed {
		logic mask_we;
		logic pay_we;
	} upd_ctl_t;

	// Brick index: upper two bits of each coordinate.
	function automatic logic [BRICK_W-1:0] brick_idx(input req_t r);
		return {r.z_coord[3:2], r.y_coord[3:2], r.x_coord[3:2]};
	endfunction

	// Voxel bit within the brick: lower two bits of each coordinate.
	function automatic logic [VBIT_W-1:0] vbit_idx(input req_t r);
		return {r.z_coord[1:0], r.y_coord[1:0], r.x_coord[1:0]};
	endfunction

endpackage

@@ hw/rtl/tlvom_req_if.sv @@
// Request channel: valid/ready handshake carrying one edit item.
interface tlvom_req_if
	import tlvom_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/tlvom_rsp_if.sv @@
// Result channel: valid/ready handshake carrying one result item.
interface tlvom_rsp_if
	import tlvom_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/two_level_voxel_occupancy_map_unit.sv @@
// Top level of the two-level voxel occupancy map with its memories and pipeline.
//
// Usage:
//   req carries edit items (set voxel, clear one voxel, clear the whole chunk,
//   or a plain read with the spare code); rsp returns one result per item with
//   the top mask, the addressed brick's mask, its presence, the voxel's state
//   and its payload, all as they stand after the edit.
//   An item accepted into the modify stage has its result in the output
//   register once that register is free. The brick mask RAM and payload
//   RAM are read in the accept cycle and written back when the item leaves
//   the modify stage; a write forwarded into a same-entry read lets edits
//   follow each other at one item per cycle while the receiver keeps up.
//   Reset clears the top occupancy mask and the valid flags; the RAMs are
//   not cleared, since every entry is read only behind a set top bit or a set
//   voxel bit, so the block takes items from the first cycle after reset.
//   When the receiver stalls, the finished result waits in the output
//   register and the next item waits in the modify stage; req.ready drops
//   only once both are full.
module two_level_voxel_occupancy_map_unit
	import tlvom_pkg::*;
#(
	parameter int unsigned PAYLOAD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	tlvom_req_if.sink   req,
	tlvom_rsp_if.source rsp
);
	logic               v_s1;
	op_t                op_s1;
	logic [BRICK_W-1:0] brick_s1;
	logic [VBIT_W-1:0]  vbit_s1;
	logic [VALUE_W-1:0] value_s1;

	logic [MASK_W-1:0]  top_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               adv;
	logic [BRICK_W-1:0] brick_in;
	logic [VBIT_W-1:0]  vbit_in;

	logic [MASK_W-1:0]        top_next;
	upd_ctl_t                 ctl;
	logic [MASK_W-1:0]        mask_wdata;
	logic [PAYLOAD_WIDTH-1:0] pay_wdata;
	logic [MASK_W-1:0]        mask_rd;
	logic [PAYLOAD_WIDTH-1:0] pay_rd;
	rsp_t                     result;

	// Handshake: the modify stage moves on when the output register is free.
	assign adv       = v_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign accept    = req.valid && req.ready;
	assign brick_in  = brick_idx(req.data);
	assign vbit_in   = vbit_idx(req.data);

	// Brick mask memory, one row per brick.
	tlvom_ram #(
		.WIDTH (MASK_W),
		.ADDR_W(BRICK_W)
	) u_mask_ram (
		.clk  (clk),
		.we   (adv && ctl.mask_we),
		.waddr(brick_s1),
		.wdata(mask_wdata),
		.re   (accept),
		.raddr(brick_in),
		.rdata(mask_rd)
	);

	// Payload memory, one entry per voxel.
	tlvom_ram #(
		.WIDTH (PAYLOAD_WIDTH),
		.ADDR_W(SLOT_W)
	) u_pay_ram (
		.clk  (clk),
		.we   (adv && ctl.pay_we),
		.waddr({brick_s1, vbit_s1}),
		.wdata(pay_wdata),
		.re   (accept),
		.raddr({brick_in, vbit_in}),
		.rdata(pay_rd)
	);

	// Modify logic of the item in the modify stage.
	tlvom_update #(
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) u_update (
		.op        (op_s1),
		.brick     (brick_s1),
		.vbit      (vbit_s1),
		.value     (value_s1),
		.top_cur   (top_q),
		.mask_rd   (mask_rd),
		.pay_rd    (pay_rd),
		.top_next  (top_next),
		.ctl       (ctl),
		.mask_wdata(mask_wdata),
		.pay_wdata (pay_wdata),
		.result    (result)
	);

	// Stage and output valid flags, top occupancy mask.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
			top_q       <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
				top_q       <= top_next;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the modify stage and of the output.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(req.data.operation);
			brick_s1 <= brick_in;
			vbit_s1  <= vbit_in;
			value_s1 <= req.data.voxel_value;
		end
		if (adv) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef ASSERT_OFF
	// An occupied voxel always lies in a present brick.
	a_occ_in_present: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.voxel_occupied |-> rsp_q.brick_present)
		else $error("occupied voxel reported in an absent brick");

	// An absent brick reports an empty mask.
	a_absent_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.brick_present |-> rsp_q.brick_mask == '0)
		else $error("absent brick reports a nonzero mask");

	// A present brick never has an empty mask.
	a_present_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.brick_present |-> rsp_q.brick_mask != '0)
		else $error("present brick reports an empty mask");

	// Clearing the chunk empties the top mask.
	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (op_s1 == OP_CLR_ALL) |=> top_q == '0)
		else $error("top mask not cleared by clear-all");
`endif
endmodule

@@ hw/rtl/tlvom_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with write-to-read bypass.
module tlvom_ram #(
	parameter int unsigned WIDTH  = 64,
	parameter int unsigned ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	localparam int unsigned DEPTH = 1 << ADDR_W;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; a write to the same entry in the same cycle is forwarded.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hw/rtl/tlvom_update.sv @@
// Modify step: computes new masks, write enables and the result for one item.
module tlvom_update
	import tlvom_pkg::*;
#(
	parameter int unsigned PAYLOAD_WIDTH = 32
) (
	input  op_t                      op,
	input  logic [BRICK_W-1:0]       brick,
	input  logic [VBIT_W-1:0]        vbit,
	input  logic [VALUE_W-1:0]       value,
	input  logic [MASK_W-1:0]        top_cur,
	input  logic [MASK_W-1:0]        mask_rd,
	input  logic [PAYLOAD_WIDTH-1:0] pay_rd,
	output logic [MASK_W-1:0]        top_next,
	output upd_ctl_t                 ctl,
	output logic [MASK_W-1:0]        mask_wdata,
	output logic [PAYLOAD_WIDTH-1:0] pay_wdata,
	output rsp_t                     result
);
	logic [MASK_W-1:0] brick_bit;
	logic [MASK_W-1:0] voxel_bit;
	logic              present_old;
	logic [MASK_W-1:0] mask_old;
	logic              present_new;
	logic [MASK_W-1:0] mask_new;
	logic [MASK_W-1:0] mask_out;
	logic              occupied;
	logic [63:0]       value_ext;
	logic [63:0]       pay_ext;

	assign brick_bit   = MASK_W'(1) << brick;
	assign voxel_bit   = MASK_W'(1) << vbit;
	assign present_old = top_cur[brick];
	assign mask_old    = present_old ? mask_rd : '0;
	assign value_ext   = 64'(value);
	assign pay_wdata   = value_ext[PAYLOAD_WIDTH-1:0];

	// State update per operation.
	always_comb begin
		top_next    = top_cur;
		ctl.mask_we = 1'b0;
		ctl.pay_we  = 1'b0;
		mask_new    = mask_old;
		unique case (op)
			OP_SET: begin
				mask_new    = mask_old | voxel_bit;
				ctl.mask_we = 1'b1;
				ctl.pay_we  = 1'b1;
				top_next    = top_cur | brick_bit;
			end
			OP_CLR_ONE: begin
				if (present_old) begin
					mask_new    = mask_rd & ~voxel_bit;
					ctl.mask_we = 1'b1;
					if (mask_new == '0) begin
						top_next = top_cur & ~brick_bit;
					end
				end
			end
			OP_CLR_ALL: begin
				top_next = '0;
			end
			OP_READ: begin
			end
			default: begin
			end
		endcase
	end

	assign mask_wdata = mask_new;

	// Result seen after the operation.
	assign present_new = top_next[brick];
	assign mask_out    = present_new ? mask_new : '0;
	assign occupied    = mask_out[vbit];
	assign pay_ext     = (op == OP_SET) ? 64'(pay_wdata) : 64'(pay_rd);

	always_comb begin
		result.top_mask       = top_next;
		result.brick_mask     = mask_out;
		result.brick_present  = present_new;
		result.voxel_occupied = occupied;
		result.stored_value   = occupied ? pay_ext[VALUE_W-1:0] : '0;
	end
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the two-level voxel occupancy map unit.
`timescale 1ns / 1ps

module testbench;
	import tlvom_pkg::*;

	localparam int unsigned PAYLOAD_BITS  = 32;
	localparam int unsigned RANDOM_EDITS  = 1528;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam logic [VALUE_W-1:0] PAYLOAD_KEEP =
		(PAYLOAD_BITS >= VALUE_W) ? '1 : VALUE_W'((64'd1 << PAYLOAD_BITS) - 1);

	// One row of the directed script; fixed rows carry a hand-written result.
	typedef struct {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [VALUE_W-1:0] value;
		bit                 fixed;
		rsp_t               result;
	} script_row_t;

	// Hand-written result waiting for its item to be accepted.
	typedef struct {
		bit   fixed;
		rsp_t result;
	} result_note_t;

	logic clk;
	logic arst_n;

	tlvom_req_if edit_ch();
	tlvom_rsp_if result_ch();

	two_level_voxel_occupancy_map_unit #(
		.PAYLOAD_WIDTH(PAYLOAD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(edit_ch),
		.rsp(result_ch)
	);

	// Mirror of the map state.
	logic [MASK_W-1:0]  occ_top;
	logic [MASK_W-1:0]  occ_brick_mask [64];
	logic [VALUE_W-1:0] occ_payload [4096];

	rsp_t         pending_results[$];
	result_note_t result_notes[$];
	script_row_t  script_rows[$];
	logic [BRICK_W-1:0] focus_brick [3];

	int unsigned edit_gap_pct;
	int unsigned result_stall_pct;
	bit          hold_request;
	int unsigned fault_count;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one edit to the mirrored map and return the result it must produce.
	function automatic rsp_t occupancy_apply(input req_t r);
		logic [BRICK_W-1:0] brick;
		logic [VBIT_W-1:0]  vbit;
		logic [SLOT_W-1:0]  slot;
		logic [MASK_W-1:0]  brick_bit;
		logic [MASK_W-1:0]  voxel_bit;
		logic [MASK_W-1:0]  mask;
		rsp_t               res;
		brick     = {r.z_coord[3:2], r.y_coord[3:2], r.x_coord[3:2]};
		vbit      = {r.z_coord[1:0], r.y_coord[1:0], r.x_coord[1:0]};
		slot      = {brick, vbit};
		brick_bit = 64'd1 << brick;
		voxel_bit = 64'd1 << vbit;
		case (op_t'(r.operation))
			OP_SET: begin
				// An absent brick starts over with only the new voxel.
				mask = ((occ_top & brick_bit) != '0) ? occ_brick_mask[brick] : '0;
				occ_brick_mask[brick] = mask | voxel_bit;
				occ_payload[slot] = r.voxel_value & PAYLOAD_KEEP;
				occ_top = occ_top | brick_bit;
			end
			OP_CLR_ONE: begin
				if ((occ_top & brick_bit) != '0) begin
					mask = occ_brick_mask[brick] & ~voxel_bit;
					occ_brick_mask[brick] = mask;
					if (mask == '0)
						occ_top = occ_top & ~brick_bit;
				end
			end
			OP_CLR_ALL: occ_top = '0;
			default: ;
		endcase
		res.top_mask       = occ_top;
		res.brick_present  = (occ_top & brick_bit) != '0;
		res.brick_mask     = res.brick_present ? occ_brick_mask[brick] : '0;
		res.voxel_occupied = (res.brick_mask & voxel_bit) != '0;
		res.stored_value   = res.voxel_occupied ? occ_payload[slot] : '0;
		return res;
	endfunction

	function automatic rsp_t result_of(input logic [MASK_W-1:0] top, input logic [MASK_W-1:0] bm,
			input logic present, input logic occupied, input logic [VALUE_W-1:0] value);
		rsp_t res;
		res.top_mask       = top;
		res.brick_mask     = bm;
		res.brick_present  = present;
		res.voxel_occupied = occupied;
		res.stored_value   = value;
		return res;
	endfunction

	function automatic void add_row(input op_t op, input int unsigned x, input int unsigned y,
			input int unsigned z, input logic [VALUE_W-1:0] value, input bit fixed,
			input rsp_t result);
		script_row_t row;
		row.op     = op;
		row.x      = COORD_W'(x);
		row.y      = COORD_W'(y);
		row.z      = COORD_W'(z);
		row.value  = value;
		row.fixed  = fixed;
		row.result = result;
		script_rows.push_back(row);
	endfunction

	// Random edit; most land on a few focus bricks and a handful of voxels in each,
	// so that sets and clears collide and bricks fill up and empty out again.
	function automatic req_t random_edit();
		req_t               r;
		int unsigned        pick;
		logic [BRICK_W-1:0] b;
		pick = $urandom_range(99);
		if (pick < 2)
			r.operation = OP_CLR_ALL;
		else if (pick < 8)
			r.operation = OP_READ;
		else if (pick < 52)
			r.operation = OP_SET;
		else
			r.operation = OP_CLR_ONE;
		r.voxel_value = $urandom();
		if ($urandom_range(99) < 75) begin
			b = focus_brick[$urandom_range(2)];
			r.x_coord = {b[1:0], 2'($urandom_range(3))};
			r.y_coord = {b[3:2], 1'b0, 1'($urandom_range(1))};
			r.z_coord = {b[5:4], 2'b00};
		end else begin
			r.x_coord = 4'($urandom_range(15));
			r.y_coord = 4'($urandom_range(15));
			r.z_coord = 4'($urandom_range(15));
		end
		return r;
	endfunction

	// Offer one item, with random gaps before it, and wait until it is taken.
	task automatic send_edit(input req_t item, input bit fixed, input rsp_t result);
		result_note_t note;
		while ($urandom_range(99) < edit_gap_pct) begin
			edit_ch.valid <= 1'b0;
			@(posedge clk);
		end
		note.fixed  = fixed;
		note.result = result;
		result_notes.push_back(note);
		edit_ch.valid <= 1'b1;
		edit_ch.data  <= item;
		@(posedge clk);
		while (!edit_ch.ready)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input rsp_t want, input rsp_t got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("mismatch: expected top=%h brick=%h present=%b occupied=%b value=%h, got top=%h brick=%h present=%b occupied=%b value=%h",
				want.top_mask, want.brick_mask, want.brick_present, want.voxel_occupied,
				want.stored_value, got.top_mask, got.brick_mask, got.brick_present,
				got.voxel_occupied, got.stored_value);
	endtask

	// Predict on every accepted edit and check every accepted result.
	always @(posedge clk) begin
		rsp_t         predicted;
		rsp_t         want;
		result_note_t note;
		if (edit_ch.valid === 1'b1 && edit_ch.ready === 1'b1) begin
			predicted = occupancy_apply(edit_ch.data);
			note = result_notes.pop_front();
			pending_results.push_back(note.fixed ? note.result : predicted);
		end
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("unexpected result: top=%h brick=%h", result_ch.data.top_mask,
						result_ch.data.brick_mask);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.data.top_mask !== want.top_mask ||
						result_ch.data.brick_mask !== want.brick_mask ||
						result_ch.data.brick_present !== want.brick_present ||
						result_ch.data.voxel_occupied !== want.voxel_occupied ||
						result_ch.data.stored_value !== want.stored_value)
					report_mismatch(want, result_ch.data);
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when asked for.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= result_stall_pct);
			end
		end
	end

	// Watchdog.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("two_level_voxel_occupancy_map_unit verification failed");
		$finish;
	end

	// Stimulus.
	initial begin
		req_t item;
		occ_top          = '0;
		fault_count      = 0;
		hold_request     = 1'b0;
		edit_gap_pct     = 10;
		result_stall_pct = 85;
		for (int i = 0; i < 64; i++)
			occ_brick_mask[i] = '0;
		for (int i = 0; i < 4096; i++)
			occ_payload[i] = '0;
		arst_n = 1'b0;
		edit_ch.valid <= 1'b0;
		edit_ch.data  <= '0;

		// Directed script: reset state, field extremes, every operation and the
		// special cases (fresh brick, clear on an absent brick, chunk clear).
		add_row(OP_READ, 0, 0, 0, 32'h0, 1, '0);
		add_row(OP_SET, 0, 0, 0, 32'hFFFF_FFFF, 1,
			result_of(64'h1, 64'h1, 1'b1, 1'b1, 32'hFFFF_FFFF));
		add_row(OP_SET, 15, 15, 15, 32'h0, 1,
			result_of(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 32'h0));
		add_row(OP_SET, 3, 3, 3, 32'h1234_5678, 0, '0);
		add_row(OP_READ, 15, 15, 15, 32'hFFFF_FFFF, 1,
			result_of(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 32'h0));
		add_row(OP_CLR_ONE, 2, 0, 0, 32'h0, 0, '0);
		add_row(OP_CLR_ONE, 3, 3, 3, 32'h0, 0, '0);
		add_row(OP_READ, 3, 3, 3, 32'h0, 0, '0);
		add_row(OP_CLR_ALL, 7, 9, 5, 32'hA5A5_A5A5, 1, '0);
		add_row(OP_CLR_ONE, 0, 0, 0, 32'h0, 1, '0);
		add_row(OP_READ, 0, 0, 0, 32'h0, 1, '0);
		add_row(OP_SET, 1, 0, 0, 32'h1, 1, result_of(64'h1, 64'h2, 1'b1, 1'b1, 32'h1));
		add_row(OP_READ, 0, 0, 0, 32'h0, 1, result_of(64'h1, 64'h2, 1'b1, 1'b0, 32'h0));
		add_row(OP_SET, 15, 0, 0, 32'hDEAD_BEEF, 0, '0);
		add_row(OP_SET, 0, 15, 0, 32'h8000_0000, 0, '0);
		add_row(OP_SET, 0, 0, 15, 32'h7FFF_FFFF, 0, '0);
		add_row(OP_CLR_ONE, 1, 0, 0, 32'h0, 0, '0);
		add_row(OP_CLR_ONE, 1, 0, 0, 32'h0, 0, '0);
		add_row(OP_SET, 15, 15, 15, 32'hFFFF_FFFF, 0, '0);
		add_row(OP_SET, 15, 15, 15, 32'h1357_9BDF, 0, '0);
		add_row(OP_READ, 15, 15, 15, 32'h0, 0, '0);
		add_row(OP_CLR_ALL, 0, 0, 0, 32'h0, 1, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script_rows[i]) begin
			item.operation   = script_rows[i].op;
			item.x_coord     = script_rows[i].x;
			item.y_coord     = script_rows[i].y;
			item.z_coord     = script_rows[i].z;
			item.voxel_value = script_rows[i].value;
			send_edit(item, script_rows[i].fixed, script_rows[i].result);
		end

		// Random edits in three idling phases; the long hold-off falls in the last.
		for (int n = 0; n < RANDOM_EDITS; n++) begin
			if (n % 100 == 0)
				for (int k = 0; k < 3; k++)
					focus_brick[k] = BRICK_W'($urandom_range(63));
			if (n == RANDOM_EDITS / 3) begin
				edit_gap_pct     = 85;
				result_stall_pct = 10;
			end
			if (n == 2 * RANDOM_EDITS / 3) begin
				edit_gap_pct     = 0;
				result_stall_pct = 0;
			end
			if (n == 5 * RANDOM_EDITS / 6)
				hold_request = 1'b1;
			send_edit(random_edit(), 1'b0, '0);
		end
		edit_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0 && pending_results.size() == 0)
			$display("two_level_voxel_occupancy_map_unit verification clean");
		else
			$display("two_level_voxel_occupancy_map_unit verification failed");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/tlvom_pkg.sv
hw/rtl/tlvom_req_if.sv
hw/rtl/tlvom_rsp_if.sv
hw/rtl/tlvom_ram.sv
hw/rtl/tlvom_update.sv
hw/rtl/two_level_voxel_occupancy_map_unit.sv
dv/testbench.sv
